@@ src/rmth_pkg.sv @@
// Shared types and codes for the running median two-heap unit.
package rmth_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_PU_CHK,
    ST_PU_CMP,
    ST_BAL,
    ST_PO_TOP,
    ST_PO_LAST,
    ST_SD_L,
    ST_SD_R,
    ST_SD_CMP,
    ST_MED
  } rmth_state_e;

  // Heap select codes.
  localparam logic HEAP_LO = 1'b0;  // max-heap, lower half
  localparam logic HEAP_HI = 1'b1;  // min-heap, upper half

  // Width of the count field of a result.
  localparam int unsigned CountW = 10;

endpackage

@@ src/running_median_two_heaps_unit.sv @@
// Running median over all samples since reset, kept in a max-heap and a min-heap.
//
// Each sample is pushed into the lower (max) heap or the upper (min) heap, and
// the heaps are then rebalanced so that their sizes differ by at most one. After
// an odd total count a result carries the median (top of the larger heap). After
// an even count no result is produced. Once 2*HEAP_DEPTH-1 samples are stored,
// a further sample is dropped and a result is produced with the overflow flag
// set in tuser, the median field at zero and count at the current total.
// Both heaps live in single-port-write, registered-read memories. One small
// sequencer walks the heap levels with one memory read per cycle: a push climbs
// levels toward the root, a pop descends levels from the root, and a rebalance
// move is a pop from one heap and a push into the other. The input is not
// ready while a sample is being worked on. No clearing pass is needed after
// reset: only entries below the current heap sizes are ever read.
module running_median_two_heaps_unit
  import rmth_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] median, [41:32] count, zero fill
  output logic        m_axis_tuser_o    // [0] overflow
);

  localparam int unsigned IW = $clog2(HEAP_DEPTH);  // heap index width
  localparam int unsigned SW = IW + 1;              // heap size width
  localparam int unsigned TW = IW + 2;              // total and child index width
  localparam logic [TW-1:0] Cap = TW'(2 * HEAP_DEPTH - 1);

  // Heap storage.
  logic signed [31:0] lo_mem [HEAP_DEPTH];
  logic signed [31:0] hi_mem [HEAP_DEPTH];

  rmth_state_e        state_q, state_d;
  logic               sel_q, sel_d;        // heap under work
  logic signed [31:0] val_q, val_d;        // value being placed
  logic signed [31:0] top_q, top_d;        // popped top, moves to other heap
  logic signed [31:0] lval_q, lval_d;      // left child value
  logic               rok_q, rok_d;        // right child exists
  logic [IW-1:0]      idx_q, idx_d;        // hole index
  logic [SW-1:0]      lsize_q, lsize_d;
  logic [SW-1:0]      usize_q, usize_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_median_q, out_median_d;
  logic [CountW-1:0]  out_count_q, out_count_d;
  logic               out_ovf_q, out_ovf_d;

  // Memory ports.
  logic [IW-1:0]      rd_addr;
  logic signed [31:0] rd_lo_q, rd_hi_q;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  logic               accept;
  logic               out_free;
  logic [TW-1:0]      total;
  logic [31:0]        total_ext;
  logic signed [31:0] rdata;
  logic [SW-1:0]      cur_size;
  logic [IW-1:0]      parent;
  logic [TW-1:0]      lchild;
  logic [TW-1:0]      rchild;
  logic               is_max;

  assign total     = TW'(lsize_q) + TW'(usize_q);
  assign total_ext = 32'(total);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign rdata     = (sel_q == HEAP_HI) ? rd_hi_q : rd_lo_q;
  assign cur_size  = (sel_q == HEAP_HI) ? usize_q : lsize_q;
  assign parent    = IW'((idx_q - IW'(1)) >> 1);
  assign lchild    = {1'b0, idx_q, 1'b1};
  assign rchild    = lchild + TW'(1);
  assign is_max    = (sel_q == HEAP_LO);

  function automatic logic above(input logic mx, input logic signed [31:0] a,
                                 input logic signed [31:0] b);
    return mx ? (a > b) : (a < b);
  endfunction

  // Next state and datapath.
  always_comb begin
    state_d      = state_q;
    sel_d        = sel_q;
    val_d        = val_q;
    top_d        = top_q;
    lval_d       = lval_q;
    rok_d        = rok_q;
    idx_d        = idx_q;
    lsize_d      = lsize_q;
    usize_d      = usize_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_median_d = out_median_q;
    out_count_d  = out_count_q;
    out_ovf_d    = out_ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d = s_axis_tdata_i;
          if (total >= Cap) begin
            // Store full: drop the sample, report overflow.
            out_valid_d  = 1'b1;
            out_median_d = '0;
            out_count_d  = total_ext[CountW-1:0];
            out_ovf_d    = 1'b1;
          end else if (lsize_q == '0) begin
            sel_d   = HEAP_LO;
            idx_d   = '0;
            lsize_d = lsize_q + SW'(1);
            state_d = ST_PU_CHK;
          end else begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        // Lower top is on the read port now.
        idx_d   = '0;
        state_d = ST_PU_CHK;
        if (val_q <= rd_lo_q) begin
          sel_d   = HEAP_LO;
          idx_d   = lsize_q[IW-1:0];
          lsize_d = lsize_q + SW'(1);
        end else begin
          sel_d   = HEAP_HI;
          idx_d   = usize_q[IW-1:0];
          usize_d = usize_q + SW'(1);
        end
      end
      ST_PU_CHK: begin
        state_d = (idx_q == '0) ? ST_BAL : ST_PU_CMP;
      end
      ST_PU_CMP: begin
        if (above(is_max, val_q, rdata)) begin
          idx_d   = parent;
          state_d = ST_PU_CHK;
        end else begin
          state_d = ST_BAL;
        end
      end
      ST_BAL: begin
        if (lsize_q > usize_q + SW'(1)) begin
          sel_d   = HEAP_LO;
          state_d = ST_PO_TOP;
        end else if (usize_q > lsize_q + SW'(1)) begin
          sel_d   = HEAP_HI;
          state_d = ST_PO_TOP;
        end else if (total[0]) begin
          sel_d   = (lsize_q > usize_q) ? HEAP_LO : HEAP_HI;
          state_d = ST_MED;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PO_TOP: begin
        top_d = rdata;
        if (sel_q == HEAP_HI) begin
          usize_d = usize_q - SW'(1);
        end else begin
          lsize_d = lsize_q - SW'(1);
        end
        state_d = ST_PO_LAST;
      end
      ST_PO_LAST: begin
        val_d   = rdata;
        idx_d   = '0;
        state_d = ST_SD_L;
      end
      ST_SD_L: begin
        if (lchild < TW'(cur_size)) begin
          state_d = ST_SD_R;
        end else begin
          // Hole settles; move the popped top to the other heap.
          val_d   = top_q;
          sel_d   = !sel_q;
          state_d = ST_PU_CHK;
          if (sel_q == HEAP_HI) begin
            idx_d   = lsize_q[IW-1:0];
            lsize_d = lsize_q + SW'(1);
          end else begin
            idx_d   = usize_q[IW-1:0];
            usize_d = usize_q + SW'(1);
          end
        end
      end
      ST_SD_R: begin
        lval_d  = rdata;
        rok_d   = rchild < TW'(cur_size);
        state_d = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        if (rok_q && above(is_max, rdata, above(is_max, lval_q, val_q) ? lval_q : val_q)) begin
          idx_d   = rchild[IW-1:0];
          state_d = ST_SD_L;
        end else if (above(is_max, lval_q, val_q)) begin
          idx_d   = lchild[IW-1:0];
          state_d = ST_SD_L;
        end else begin
          val_d   = top_q;
          sel_d   = !sel_q;
          state_d = ST_PU_CHK;
          if (sel_q == HEAP_HI) begin
            idx_d   = lsize_q[IW-1:0];
            lsize_d = lsize_q + SW'(1);
          end else begin
            idx_d   = usize_q[IW-1:0];
            usize_d = usize_q + SW'(1);
          end
        end
      end
      ST_MED: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_median_d = rdata;
          out_count_d  = total_ext[CountW-1:0];
          out_ovf_d    = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = val_q;
    s_axis_tready_o = (state_q == ST_IDLE) && out_free;
    case (state_q)
      ST_PU_CHK: begin
        if (idx_q == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = parent;
        end
      end
      ST_PU_CMP: begin
        wr_en = 1'b1;
        if (above(is_max, val_q, rdata)) begin
          wr_data = rdata;
        end
      end
      ST_PO_TOP: begin
        rd_addr = IW'(cur_size - SW'(1));
      end
      ST_SD_L: begin
        if (lchild < TW'(cur_size)) begin
          rd_addr = lchild[IW-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      ST_SD_R: begin
        rd_addr = rchild[IW-1:0];
      end
      ST_SD_CMP: begin
        wr_en = 1'b1;
        if (rok_q && above(is_max, rdata, above(is_max, lval_q, val_q) ? lval_q : val_q)) begin
          wr_data = rdata;
        end else if (above(is_max, lval_q, val_q)) begin
          wr_data = lval_q;
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Heap memories: one write, one registered read each.
  always_ff @(posedge clk_i) begin
    if (wr_en && sel_q == HEAP_LO) begin
      lo_mem[wr_addr] <= wr_data;
    end
    if (wr_en && sel_q == HEAP_HI) begin
      hi_mem[wr_addr] <= wr_data;
    end
    rd_lo_q <= lo_mem[rd_addr];
    rd_hi_q <= hi_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lsize_q     <= '0;
      usize_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lsize_q     <= lsize_d;
      usize_q     <= usize_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk_i) begin
    sel_q        <= sel_d;
    val_q        <= val_d;
    top_q        <= top_d;
    lval_q       <= lval_d;
    rok_q        <= rok_d;
    idx_q        <= idx_d;
    out_median_q <= out_median_d;
    out_count_q  <= out_count_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_count_q, out_median_q};
  assign m_axis_tuser_o  = out_ovf_q;

`ifndef SYNTH
  // Heaps are balanced whenever a new sample can be taken.
  a_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> (lsize_q <= usize_q + SW'(1)) && (usize_q <= lsize_q + SW'(1)))
    else $error("heaps out of balance when idle");
  // Stored total never exceeds capacity.
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> total <= Cap)
    else $error("heap store over capacity");
  // An overflow result carries a zero median.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ovf_q |-> out_median_q == '0)
    else $error("overflow result with nonzero median");
  // A median result follows only an odd count.
  a_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ovf_q |-> out_count_q[0])
    else $error("median result after even count");
`endif

endmodule

@@ test/running_median_two_heaps_unit_tb.sv @@
// Self-checking testbench for the running median two-heap unit.
module running_median_two_heaps_unit_tb
  import rmth_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 512;
  localparam int unsigned Capacity = 2 * Depth - 1;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    logic signed [31:0] median;
    logic [CountW-1:0]  count;
    logic               overflow;
  } median_result_t;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] sample
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;   // [31:0] median, [41:32] count, zero fill
  logic        m_axis_tuser_o;   // [0] overflow

  running_median_two_heaps_unit #(.HEAP_DEPTH(Depth)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  // Samples waiting to be sent, and medians waiting to come out.
  logic signed [31:0] sample_q[$];
  median_result_t     median_q[$];

  // Predictor copy of both heaps; only the multiset matters, so keep each sorted.
  logic signed [31:0] lower_vals[$];   // ascending, top is the last entry
  logic signed [31:0] upper_vals[$];   // ascending, top is the first entry

  idle_phase_e phase;
  bit          hold_recv;   // long receiver hold-off for back-pressure
  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned result_count;
  int unsigned overflow_seen;
  int unsigned idle_cycles;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Insert into an ascending queue, keeping order.
  function automatic void sorted_insert(ref logic signed [31:0] q[$], input logic signed [31:0] v);
    int idx;
    idx = 0;
    while (idx < q.size() && q[idx] < v) idx++;
    q.insert(idx, v);
  endfunction

  // Fold one sample into the two halves; return 1 with the median result if one is due.
  function automatic bit fold_sample(input logic signed [31:0] v, output median_result_t res);
    int unsigned total;
    logic signed [31:0] t;
    total = lower_vals.size() + upper_vals.size();
    res = '0;
    if (total >= Capacity) begin
      res.count = total[CountW-1:0];
      res.overflow = 1'b1;
      return 1'b1;
    end
    if (lower_vals.size() == 0 || v <= lower_vals[$]) sorted_insert(lower_vals, v);
    else sorted_insert(upper_vals, v);
    // Move tops across until the halves differ by at most one.
    while (lower_vals.size() > upper_vals.size() + 1 ||
           upper_vals.size() > lower_vals.size() + 1) begin
      if (lower_vals.size() > upper_vals.size()) begin
        t = lower_vals.pop_back();
        upper_vals.push_front(t);
      end else begin
        t = upper_vals.pop_front();
        lower_vals.push_back(t);
      end
    end
    total = lower_vals.size() + upper_vals.size();
    if (total[0] == 1'b0) return 1'b0;
    res.median = (lower_vals.size() > upper_vals.size()) ? lower_vals[$] : upper_vals[0];
    res.count = total[CountW-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic bit idle_roll(input bit sender);
    case (phase)
      PH_SEND_IDLE:  return sender && ($urandom_range(99) < 52);
      PH_RECV_STALL: return !sender && ($urandom_range(99) < 52);
      PH_BOTH:       return $urandom_range(99) < 9;
      default:       return 1'b0;
    endcase
  endfunction

  // Driver: present the head sample, advance on each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    median_result_t res;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
    end else if (s_axis_tvalid_i && !s_axis_tready_o) begin
      // hold the offered sample until it is taken
    end else begin
      if (s_axis_tvalid_i) begin
        if (fold_sample(s_axis_tdata_i, res)) median_q.push_back(res);
        void'(sample_q.pop_front());
        sent_count++;
      end
      if (sample_q.size() > 0 && !idle_roll(1'b1)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= sample_q[0];
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    median_result_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        result_count++;
        if (m_axis_tuser_o) overflow_seen++;
        if (median_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata_o, 0);
        end else begin
          want = median_q.pop_front();
          if (m_axis_tdata_o[31:0] !== want.median)
            report_mismatch("median", m_axis_tdata_o[31:0], want.median);
          if (m_axis_tdata_o[41:32] !== want.count)
            report_mismatch("count", m_axis_tdata_o[41:32], want.count);
          if (m_axis_tdata_o[47:42] !== '0)
            report_mismatch("fill", m_axis_tdata_o[47:42], 0);
          if (m_axis_tuser_o !== want.overflow)
            report_mismatch("overflow", m_axis_tuser_o, want.overflow);
        end
      end
      m_axis_tready_i <= !hold_recv && !idle_roll(1'b0);
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout with %0d samples pending", sample_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom_range(15) - 8;                       // dense small values, many ties
      1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFF0} + $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (sample_q.size() > 0 || s_axis_tvalid_i || median_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    phase = PH_FREE;
    hold_recv = 1'b0;
    fail_count = 0;
    sent_count = 0;
    result_count = 0;
    overflow_seen = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first sample, extremes, ties, both sides of the lower top.
    sample_q.push_back(32'sd5);
    sample_q.push_back(32'h8000_0000);
    sample_q.push_back(32'h7FFF_FFFF);
    sample_q.push_back(32'h7FFF_FFFF);
    sample_q.push_back(32'h8000_0000);
    sample_q.push_back(32'sd0);
    sample_q.push_back(-32'sd1);
    sample_q.push_back(32'sd5);
    sample_q.push_back(32'sd5);
    sample_q.push_back(32'h5555_5555);
    sample_q.push_back(32'hAAAA_AAAA);
    for (int k = 0; k < 8; k++) sample_q.push_back(32'sd100 - k);
    for (int k = 0; k < 4; k++) sample_q.push_back(-32'sd100 + k);
    wait_drained();

    // Random phases; in the sender-gap phase the receiver is also held off for a long stretch.
    for (int p = 0; p < 5; p++) begin
      phase = idle_phase_e'(p % 4);
      for (int k = 0; k < 200; k++) sample_q.push_back(rand_sample());
      if (p == 1) begin
        hold_recv = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      wait_drained();
    end

    // Fill the store to capacity and push past it to exercise the overflow path.
    phase = PH_BOTH;
    while (sent_count + sample_q.size() < Capacity + 5) sample_q.push_back(rand_sample());
    wait_drained();
    // Past capacity every sample overflows; keep the tail going.
    for (int k = 0; k < 320; k++) sample_q.push_back(rand_sample());
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d samples, checked %0d results (%0d overflow)",
             sent_count, result_count, overflow_seen);
    $display("idle phases covered: free, sender gaps, receiver stalls, both, long hold-off");
    if (fail_count == 0 && median_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
